[hw/rtl/mhfd_pkg.sv]
// ----------------------------------------------------------------------------
// mhfd_pkg
// Shared types and constants of the magic header frame deframer.
// ----------------------------------------------------------------------------
package mhfd_pkg;

    localparam int unsigned HDR_BYTES   = 20;
    localparam int unsigned REPLAY_LEN  = 16;
    localparam int unsigned IN_DEPTH    = 4;
    localparam logic [31:0] LIMIT_RESET = 32'd33177600;

    localparam logic [7:0] MAGIC_0 = 8'h45;
    localparam logic [7:0] MAGIC_1 = 8'h56;
    localparam logic [7:0] MAGIC_2 = 8'h52;
    localparam logic [7:0] MAGIC_3 = 8'h47;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic        frame_first;
        logic        frame_last;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
    } t_out_item;

    function automatic logic [7:0] magic_at(input logic [1:0] idx);
        logic [7:0] res;
        case (idx)
            2'd0:    res = MAGIC_0;
            2'd1:    res = MAGIC_1;
            2'd2:    res = MAGIC_2;
            default: res = MAGIC_3;
        endcase
        return res;
    endfunction

endpackage

[hw/rtl/mhfd_front.sv]
// ----------------------------------------------------------------------------
// mhfd_front
// Input queue: accepts items and holds them until the parser takes them.
// ----------------------------------------------------------------------------
module mhfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mhfd_pkg::t_in_item i_item,
    output logic               o_full,
    output logic               o_valid,
    output mhfd_pkg::t_in_item o_item,
    input  logic               i_take
);

    localparam int unsigned PW = $clog2(mhfd_pkg::IN_DEPTH);

    mhfd_pkg::t_in_item r_buf [mhfd_pkg::IN_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic          w_put;
    logic          w_get;

    assign o_full  = (r_cnt == (PW+1)'(mhfd_pkg::IN_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_buf[r_rd];
    assign w_put   = i_push && !o_full;
    assign w_get   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_buf[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_put) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_get) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_put) - (PW+1)'(w_get);
        end
    end

endmodule

[hw/rtl/mhfd_back.sv]
// ----------------------------------------------------------------------------
// mhfd_back
// Parser: header search and check, payload pass, replay after a rejected
// header, and a two-entry result queue.
// ----------------------------------------------------------------------------
module mhfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mhfd_pkg::t_in_item  i_item,
    output logic                o_take,
    input  logic [31:0]         i_limit,
    input  logic                i_pop,
    output logic                o_empty,
    output mhfd_pkg::t_out_item o_item
);

    logic [7:0]  r_store [mhfd_pkg::HDR_BYTES];
    logic [7:0]  r_replay [mhfd_pkg::REPLAY_LEN];
    logic [4:0]  r_replay_cnt;
    logic [4:0]  r_count;
    logic        r_in_payload;
    logic        r_started;
    logic [31:0] r_remaining;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_prod;

    mhfd_pkg::t_out_item r_oq [2];
    logic       r_oq_wr;
    logic       r_oq_rd;
    logic [1:0] r_oq_cnt;

    logic        w_room;
    logic        w_replay;
    logic        w_step;
    logic        w_cmd;
    logic [7:0]  w_byte;
    logic [15:0] w_hw;
    logic [15:0] w_hh;
    logic [31:0] w_len;
    logic        w_bad;
    logic        w_emit;
    logic        w_pop;
    mhfd_pkg::t_out_item w_res;

    assign w_room   = (r_oq_cnt != 2'd2);
    assign w_replay = (r_replay_cnt != '0);
    assign w_step   = w_room && (w_replay || i_valid);
    assign o_take   = w_room && !w_replay;
    assign w_cmd    = w_replay ? mhfd_pkg::CMD_DATA : i_item.command;
    assign w_byte   = w_replay ? r_replay[0] : i_item.data_byte;
    assign w_hw     = {r_store[5], r_store[4]};
    assign w_hh     = {r_store[7], r_store[6]};
    assign w_len    = {w_byte, r_store[18], r_store[17], r_store[16]};
    assign w_bad    = (w_hw == '0) || (w_hh == '0) || (w_len == '0) || (w_len > i_limit)
                   || (w_len != {r_prod[29:0], 2'b00});
    assign w_pop    = i_pop && (r_oq_cnt != '0);
    assign o_empty  = (r_oq_cnt == '0);
    assign o_item   = r_oq[r_oq_rd];

    always_comb begin
        w_emit = 1'b0;
        w_res  = '0;
        if (w_cmd == mhfd_pkg::CMD_END) begin
            w_emit            = r_in_payload;
            w_res.result_kind = mhfd_pkg::KIND_ABORT;
            w_res.frame_width  = r_width;
            w_res.frame_height = r_height;
        end else if (r_in_payload) begin
            w_emit             = 1'b1;
            w_res.result_kind  = mhfd_pkg::KIND_PAYLOAD;
            w_res.payload_byte = w_byte;
            w_res.frame_first  = !r_started;
            w_res.frame_last   = (r_remaining <= 32'd1);
            w_res.frame_width  = r_width;
            w_res.frame_height = r_height;
        end else if (r_count == 5'(mhfd_pkg::HDR_BYTES - 1)) begin
            w_emit             = w_bad;
            w_res.result_kind  = mhfd_pkg::KIND_REJECT;
            w_res.frame_width  = w_hw;
            w_res.frame_height = w_hh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_hw * w_hh;
        if (w_step && w_emit) begin
            r_oq[r_oq_wr] <= w_res;
        end
        if (w_step && w_replay) begin
            for (int i = 0; i < mhfd_pkg::REPLAY_LEN - 1; i++) begin
                r_replay[i] <= r_replay[i+1];
            end
        end
        if (w_step && w_cmd == mhfd_pkg::CMD_DATA && !r_in_payload) begin
            if (r_count == 5'(mhfd_pkg::HDR_BYTES - 1)) begin
                for (int i = 0; i < mhfd_pkg::REPLAY_LEN - 1; i++) begin
                    r_replay[i] <= r_store[i+4];
                end
                r_replay[mhfd_pkg::REPLAY_LEN-1] <= w_byte;
            end else if (r_count >= 5'd4) begin
                r_store[r_count] <= w_byte;
            end
        end
        if (!i_rst_n) begin
            r_replay_cnt <= '0;
            r_count      <= '0;
            r_in_payload <= 1'b0;
            r_started    <= 1'b0;
            r_remaining  <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_oq_wr      <= 1'b0;
            r_oq_rd      <= 1'b0;
            r_oq_cnt     <= '0;
        end else begin
            if (w_step && w_emit) begin
                r_oq_wr <= !r_oq_wr;
            end
            if (w_pop) begin
                r_oq_rd <= !r_oq_rd;
            end
            r_oq_cnt <= r_oq_cnt + 2'(w_step && w_emit) - 2'(w_pop);
            if (w_step) begin
                if (w_replay) begin
                    r_replay_cnt <= r_replay_cnt - 1'b1;
                end
                if (w_cmd == mhfd_pkg::CMD_END) begin
                    r_count      <= '0;
                    r_in_payload <= 1'b0;
                    r_started    <= 1'b0;
                    r_remaining  <= '0;
                end else if (r_in_payload) begin
                    r_started <= 1'b1;
                    if (r_remaining <= 32'd1) begin
                        r_remaining  <= '0;
                        r_in_payload <= 1'b0;
                        r_started    <= 1'b0;
                    end else begin
                        r_remaining <= r_remaining - 1'b1;
                    end
                end else if (r_count < 5'd4) begin
                    if (w_byte == mhfd_pkg::magic_at(r_count[1:0])) begin
                        r_count <= r_count + 1'b1;
                    end else if (w_byte == mhfd_pkg::MAGIC_0) begin
                        r_count <= 5'd1;
                    end else begin
                        r_count <= '0;
                    end
                end else if (r_count == 5'(mhfd_pkg::HDR_BYTES - 1)) begin
                    r_count <= '0;
                    if (w_bad) begin
                        r_replay_cnt <= 5'(mhfd_pkg::REPLAY_LEN);
                    end else begin
                        r_in_payload <= 1'b1;
                        r_started    <= 1'b0;
                        r_remaining  <= w_len;
                        r_width      <= w_hw;
                        r_height     <= w_hh;
                    end
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    a_replay_outside_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_replay_cnt != '0) |-> (!r_in_payload && r_count < 5'(mhfd_pkg::REPLAY_LEN)))
        else $error("replay while in payload or with full window");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < 5'(mhfd_pkg::HDR_BYTES))
        else $error("header window overflow");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oq_cnt != 2'd3) && !(o_take && w_replay))
        else $error("result queue overflow or input taken during replay");

    a_reject_starts_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_emit && w_res.result_kind == mhfd_pkg::KIND_REJECT)
        |=> (r_replay_cnt == 5'(mhfd_pkg::REPLAY_LEN)))
        else $error("rejected header did not start replay");

endmodule

[hw/rtl/magic_header_frame_deframer.sv]
// ----------------------------------------------------------------------------
// magic_header_frame_deframer
// Byte stream deframer: finds the magic word, checks a 20-byte header and
// passes the payload out marked first and last.
//
//   channel  handshake            payload
//   input    push / full          i_in_item  (command, data_byte)
//   result   empty / pop          o_out_item (kind, byte, first, last, w, h)
//   config   i_cfg_valid / ready  i_cfg_data (max payload bytes, always ready)
//
// One item per cycle while no replay runs and the result queue has room.
// A rejected header stops input while the parser replays its bytes 4 to 19.
// Synchronous active-low reset; no clearing pass. The input queue holds four
// items and the result queue two, so either side stalls without the other.
// ----------------------------------------------------------------------------
module magic_header_frame_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mhfd_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output mhfd_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);

    logic               w_valid;
    logic               w_take;
    mhfd_pkg::t_in_item w_item;
    logic [31:0]        r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= mhfd_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    mhfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .o_valid (w_valid),
        .o_item  (w_item),
        .i_take  (w_take)
    );

    mhfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_take  (w_take),
        .i_limit (r_limit),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_out_item)
    );

endmodule

[tb/tb_magic_header_frame_deframer.sv]
// ----------------------------------------------------------------------------
// tb_magic_header_frame_deframer
// Self-checking bench for the magic header frame deframer. Directed and
// random byte streams (good frames, bad headers, noise, connection ends) are
// pushed in. A local predictor of the header window and payload counter
// builds the expected results, which are matched in order against every
// popped result. Random idling on both sides, a long receiver hold-off and
// several payload limit settings are covered.
// ----------------------------------------------------------------------------
module tb_magic_header_frame_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned IDLE_LIMIT    = 5000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    mhfd_pkg::t_in_item   i_in_item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    mhfd_pkg::t_out_item  o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [31:0]          i_cfg_data = '0;

    magic_header_frame_deframer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // deframer state mirror
    logic [7:0]  win_bytes [mhfd_pkg::HDR_BYTES];
    int unsigned win_cnt;
    logic        in_frame;
    logic [31:0] left_bytes;
    logic        frame_begun;
    logic [15:0] cur_width;
    logic [15:0] cur_height;
    logic [31:0] payload_limit;

    mhfd_pkg::t_out_item pending_results [$];
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned frames_done;
    int unsigned rejects_seen;
    int unsigned aborts_seen;
    int unsigned idle_cycles;
    int unsigned hold_cycles;
    bit          quiet;

    function automatic void drop_window(int unsigned n);
        if (n >= win_cnt) begin
            win_cnt = 0;
        end else begin
            for (int unsigned i = 0; i < win_cnt - n; i++) begin
                win_bytes[i] = win_bytes[i + n];
            end
            win_cnt = win_cnt - n;
        end
    endfunction

    function automatic bit magic_prefix();
        bit ok;
        ok = 1'b1;
        for (int unsigned i = 0; i < win_cnt && i < 4; i++) begin
            if (win_bytes[i] != mhfd_pkg::magic_at(i[1:0])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic void resync();
        while (win_cnt > 0 && !magic_prefix()) begin
            drop_window(1);
        end
    endfunction

    function automatic void predict_item(mhfd_pkg::t_in_item it);
        mhfd_pkg::t_out_item r;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] len;
        logic [31:0] want_len;
        r = '0;
        if (it.command == mhfd_pkg::CMD_END) begin
            if (in_frame) begin
                r.result_kind  = mhfd_pkg::KIND_ABORT;
                r.frame_width  = cur_width;
                r.frame_height = cur_height;
                pending_results.push_back(r);
            end
            win_cnt = 0;
            in_frame = 1'b0;
            left_bytes = '0;
            frame_begun = 1'b0;
        end else if (in_frame) begin
            r.result_kind  = mhfd_pkg::KIND_PAYLOAD;
            r.payload_byte = it.data_byte;
            r.frame_first  = !frame_begun;
            r.frame_last   = (left_bytes <= 1);
            r.frame_width  = cur_width;
            r.frame_height = cur_height;
            pending_results.push_back(r);
            frame_begun = 1'b1;
            if (left_bytes <= 1) begin
                left_bytes = '0;
                in_frame = 1'b0;
                frame_begun = 1'b0;
            end else begin
                left_bytes = left_bytes - 1;
            end
        end else begin
            if (win_cnt < mhfd_pkg::HDR_BYTES) begin
                win_bytes[win_cnt] = it.data_byte;
                win_cnt++;
            end
            resync();
            if (win_cnt >= mhfd_pkg::HDR_BYTES) begin
                w = {24'd0, win_bytes[4]} | ({24'd0, win_bytes[5]} << 8);
                h = {24'd0, win_bytes[6]} | ({24'd0, win_bytes[7]} << 8);
                len = {win_bytes[19], win_bytes[18], win_bytes[17], win_bytes[16]};
                want_len = (w * h) * 32'd4;
                if (w == 0 || h == 0 || len == 0 || len > payload_limit ||
                    len != want_len) begin
                    drop_window(4);
                    resync();
                    r.result_kind  = mhfd_pkg::KIND_REJECT;
                    r.frame_width  = w[15:0];
                    r.frame_height = h[15:0];
                    pending_results.push_back(r);
                end else begin
                    cur_width = w[15:0];
                    cur_height = h[15:0];
                    left_bytes = len;
                    in_frame = 1'b1;
                    frame_begun = 1'b0;
                    win_cnt = 0;
                end
            end
        end
    endfunction

    task automatic send_item(logic cmd, logic [7:0] data);
        mhfd_pkg::t_in_item it;
        int unsigned gap;
        it.command = cmd;
        it.data_byte = data;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 8);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        predict_item(it);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] data);
        send_item(mhfd_pkg::CMD_DATA, data);
    endtask

    task automatic send_header(logic [15:0] w, logic [15:0] h, logic [31:0] len);
        send_byte(mhfd_pkg::MAGIC_0);
        send_byte(mhfd_pkg::MAGIC_1);
        send_byte(mhfd_pkg::MAGIC_2);
        send_byte(mhfd_pkg::MAGIC_3);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
        send_byte(h[7:0]);
        send_byte(h[15:8]);
        for (int i = 0; i < 8; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(len[23:16]);
        send_byte(len[31:24]);
    endtask

    // good header and payload; cut_at below len ends the connection there
    task automatic send_frame(logic [15:0] w, logic [15:0] h, int unsigned cut_at);
        logic [31:0] len;
        len = w * h * 4;
        send_header(w, h, len);
        for (int unsigned i = 0; i < len; i++) begin
            if (i == cut_at) begin
                send_item(mhfd_pkg::CMD_END, 8'($urandom_range(0, 255)));
                return;
            end
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || hold_cycles != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [31:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        payload_limit = value;
    endtask

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(1, 1, 32'hFFFF_FFFF);
        send_header(0, 3, 0);
        send_header(3, 0, 0);
        send_header(2, 2, 0);
        send_header(2, 2, 17);
        send_header(16'hFFFF, 16'hFFFF, 32'hFFF8_0004);
        send_header(16'h8000, 16'h8000, 0);
        send_item(mhfd_pkg::CMD_END, 8'hA5);
        send_byte(mhfd_pkg::MAGIC_0);
        send_byte(mhfd_pkg::MAGIC_1);
        send_byte(mhfd_pkg::MAGIC_0);
        send_frame(2, 1, 3);
        send_item(mhfd_pkg::CMD_END, 8'h00);
        send_byte(mhfd_pkg::MAGIC_0);
        send_frame(1, 2, 32'hFFFF_FFFF);
    endtask

    task automatic test_limit_settings();
        write_limit(32'd0);
        send_frame(1, 1, 32'hFFFF_FFFF);
        write_limit(32'd1);
        send_header(1, 1, 4);
        write_limit(32'd8);
        send_frame(2, 1, 32'hFFFF_FFFF);
        send_header(3, 1, 12);
        write_limit(32'd7);
        send_header(2, 1, 8);
        write_limit(32'hFFFF_FFFF);
        send_frame(1, 3, 32'hFFFF_FFFF);
        send_header(16'hFFFF, 16'hFFFF, 32'hFFF8_0004);
        write_limit(mhfd_pkg::LIMIT_RESET);
    endtask

    task automatic random_chunk();
        int unsigned pick;
        logic [15:0] w;
        logic [15:0] h;
        pick = $urandom_range(0, 99);
        w = 16'($urandom_range(1, 4));
        h = 16'($urandom_range(1, 4));
        if (pick < 60) begin
            send_frame(w, h, ($urandom_range(0, 9) == 0) ? $urandom_range(0, w * h * 4 - 1)
                                                         : 32'hFFFF_FFFF);
        end else if (pick < 75) begin
            case ($urandom_range(0, 4))
                0: send_header(0, h, w * h * 4);
                1: send_header(w, 0, w * h * 4);
                2: send_header(w, h, w * h * 4 + $urandom_range(1, 3));
                3: send_header(w, h, 0);
                default: begin
                    w = 16'($urandom);
                    h = 16'($urandom);
                    send_header(w, h, ($urandom_range(0, 1) == 0) ? w * h * 4 : $urandom);
                end
            endcase
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 10)) begin
                send_byte(($urandom_range(0, 2) == 0)
                          ? mhfd_pkg::magic_at(2'($urandom_range(0, 3)))
                          : 8'($urandom_range(0, 255)));
            end
        end else if (pick < 92) begin
            send_item(mhfd_pkg::CMD_END, 8'($urandom_range(0, 255)));
        end else begin
            send_byte(mhfd_pkg::MAGIC_0);
            send_byte(mhfd_pkg::MAGIC_1);
            send_frame(w, h, 32'hFFFF_FFFF);
        end
    endtask

    task automatic test_random();
        while (items_sent < 1250) begin
            random_chunk();
        end
    endtask

    task automatic test_receiver_holdoff();
        wait_idle();
        hold_cycles = 300;
        send_frame(4, 4, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_rate();
        wait_idle();
        quiet = 1'b1;
        while (items_sent < 1450) begin
            random_chunk();
        end
    endtask

    // receiver: random stall bursts, plus the long hold-off on request
    initial begin
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                pop <= 1'b0;
                hold_cycles--;
            end else if (stall != 0) begin
                pop <= 1'b0;
                stall--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                stall = $urandom_range(1, 8) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        mhfd_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: kind %0d byte %02h", o_out_item.result_kind,
                             o_out_item.payload_byte);
                end
            end else begin
                want = pending_results.pop_front();
                if (want.result_kind == mhfd_pkg::KIND_PAYLOAD && want.frame_last) begin
                    frames_done++;
                end
                if (want.result_kind == mhfd_pkg::KIND_REJECT) rejects_seen++;
                if (want.result_kind == mhfd_pkg::KIND_ABORT) aborts_seen++;
                if (o_out_item.result_kind != want.result_kind ||
                    o_out_item.payload_byte != want.payload_byte ||
                    o_out_item.frame_first != want.frame_first ||
                    o_out_item.frame_last != want.frame_last ||
                    o_out_item.frame_width != want.frame_width ||
                    o_out_item.frame_height != want.frame_height) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp kind %0d byte %02h f %0b l %0b w %0d h %0d",
                                 want.result_kind, want.payload_byte, want.frame_first,
                                 want.frame_last, want.frame_width, want.frame_height);
                        $display("          got kind %0d byte %02h f %0b l %0b w %0d h %0d",
                                 o_out_item.result_kind, o_out_item.payload_byte,
                                 o_out_item.frame_first, o_out_item.frame_last,
                                 o_out_item.frame_width, o_out_item.frame_height);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready) ||
            !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d results outstanding", pending_results.size());
                $display("tb_magic_header_frame_deframer: errors");
                $finish;
            end
        end
    end

    initial begin
        win_cnt = 0;
        in_frame = 1'b0;
        left_bytes = '0;
        frame_begun = 1'b0;
        cur_width = '0;
        cur_height = '0;
        payload_limit = mhfd_pkg::LIMIT_RESET;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        frames_done = 0;
        rejects_seen = 0;
        aborts_seen = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limit_settings();
        test_random();
        test_receiver_holdoff();
        test_full_rate();
        wait_idle();

        $display("%0d items in, %0d results out: %0d frames, %0d rejected headers, %0d aborts",
                 items_sent, results_seen, frames_done, rejects_seen, aborts_seen);
        $display("limits 0, 1, 7, 8, max and reset value; long receiver hold-off included");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_magic_header_frame_deframer: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("tb_magic_header_frame_deframer: errors");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mhfd_pkg.sv
hw/rtl/mhfd_front.sv
hw/rtl/mhfd_back.sv
hw/rtl/magic_header_frame_deframer.sv
tb/tb_magic_header_frame_deframer.sv
